// File: hw/rtl/csq_pkg.sv
`timescale 1ns / 1ps

package csq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam int IN_FIELDS_W  = CMD_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VALUE_W + 1 + CNT_W + CNT_W + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_CURRENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MOVE,
        ST_FETCH,
        ST_REPORT
    } seq_state_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    cursor_index;
        logic [CNT_W-1:0]    item_count;
        logic                has_current;
        logic [VALUE_W-1:0]  current_value;
    } result_t;

endpackage

// File: hw/rtl/csq_store.sv
`timescale 1ns / 1ps

module csq_store
    import csq_pkg::*;
(
    input  logic                  clk,
    input  mem_req_t              req,
    output logic [DATA_WIDTH-1:0] rd_data_reg
);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    // One write and one registered read per cycle; read data holds when idle.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

endmodule

// File: hw/rtl/csq_seq.sv
`timescale 1ns / 1ps

module csq_seq
    import csq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      in_command,
    input  logic [VALUE_W-1:0]    in_value,
    output mem_req_t              mem_req,
    input  logic [DATA_WIDTH-1:0] rd_data,
    input  logic                  out_free,
    output logic                  res_valid,
    output result_t               res
);

    seq_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  dir_up_reg, dir_up_next;

    logic                  accept;
    logic                  has_cur;
    logic                  full;
    logic [CNT_W-1:0]      step;
    logic                  more;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign has_cur = cursor_reg < count_reg;
    assign full    = count_reg >= CNT_W'(CAPACITY);

    // Shared index unit: neighbor index and end-of-shift compare
    assign step = dir_up_reg ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));
    assign more = dir_up_reg ? (idx_reg > cursor_reg) : (step < count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FETCH;
                    if ((in_command == CMD_INSERT || in_command == CMD_ATTACH) && !full)
                    begin
                        state_next = ST_SHIFT;
                    end
                    if (in_command == CMD_REMOVE && has_cur)
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:  state_next = more ? ST_MOVE : ST_FETCH;
            ST_MOVE:   state_next = ST_SHIFT;
            ST_FETCH:  state_next = ST_REPORT;
            ST_REPORT: state_next = out_free ? ST_IDLE : ST_REPORT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        word_next   = word_reg;
        status_next = status_reg;
        dir_up_next = dir_up_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    word_next   = in_value[DATA_WIDTH-1:0];
                    case (in_command)
                        CMD_READ:  cursor_next = cursor_reg;
                        CMD_START: cursor_next = '0;
                        CMD_ADVANCE:
                        begin
                            if (has_cur)
                            begin
                                cursor_next = cursor_reg + CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STAT_NO_CURRENT;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cursor_next = has_cur ? cursor_reg : '0;
                                idx_next    = count_reg;
                                dir_up_next = 1'b1;
                            end
                        end
                        CMD_ATTACH:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cursor_next = has_cur ? (cursor_reg + CNT_W'(1)) : count_reg;
                                idx_next    = count_reg;
                                dir_up_next = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (has_cur)
                            begin
                                idx_next    = cursor_reg;
                                dir_up_next = 1'b0;
                            end
                            else
                            begin
                                status_next = STAT_NO_CURRENT;
                            end
                        end
                        default: cursor_next = cursor_reg;
                    endcase
                end
            end
            ST_SHIFT:
            begin
                if (!more)
                begin
                    count_next = dir_up_reg ? (count_reg + CNT_W'(1))
                                            : (count_reg - CNT_W'(1));
                end
            end
            ST_MOVE: idx_next = step;
            default: idx_next = idx_reg;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = idx_reg[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = step[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_SHIFT:
            begin
                if (more)
                begin
                    mem_req.rd_en = 1'b1;
                end
                else if (dir_up_reg)
                begin
                    // drop the new word into the opened slot
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = cursor_reg[ADDR_W-1:0];
                    mem_req.wr_data = word_reg;
                end
            end
            ST_MOVE: mem_req.wr_en = 1'b1;
            ST_FETCH:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cursor_reg[ADDR_W-1:0];
            end
            ST_REPORT: res_valid = 1'b1;
            default:   res_valid = 1'b0;
        endcase
    end

    assign res.status        = status_reg;
    assign res.cursor_index  = cursor_reg;
    assign res.item_count    = count_reg;
    assign res.has_current   = has_cur;
    assign res.current_value = has_cur ? VALUE_W'(rd_data) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            status_reg <= STAT_OK;
            dir_up_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            dir_up_reg <= dir_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

`ifndef NO_ASSERTIONS
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond item count");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("item count beyond capacity");

    a_open_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && !more && dir_up_reg)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("opened slot did not grow the count");

    a_close_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && !more && !dir_up_reg)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("closed slot did not shrink the count");
`endif

endmodule

// File: hw/rtl/cursor_sequence_store.sv
`timescale 1ns / 1ps
// Read, start, advance and refused commands go from the transfer through FETCH and REPORT to
// m_axis. Insert and attach first move the entries at and above the new cursor position up and
// remove moves those above the cursor down, one entry per SHIFT and MOVE pair, through the
// one-write, one-read entry memory and the one shared index unit. A command is taken only when
// idle, after the last result left for the output register; a waiting result does not block
// the next transfer. Reset (rst_n, asynchronous, active low) empties the sequence and parks
// the cursor at 0; the entry memory is not cleared and needs no clearing pass.

module cursor_sequence_store
    import csq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] command, [34:3] entry_value, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] current_value, [32] has_current, [39:33] item_count,
    // [46:40] cursor_index, [48:47] status, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  res_valid;
    result_t               res;
    logic                  out_free;

    logic                  m_valid_reg;
    result_t               m_data_reg;

    // The output register frees up when empty or when its result is taken this cycle.
    assign out_free = !m_valid_reg || m_axis_tready;

    csq_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tdata[CMD_W-1:0]),
        .in_value   (s_axis_tdata[IN_FIELDS_W-1:CMD_W]),
        .mem_req    (mem_req),
        .rd_data    (rd_data),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    csq_store u_store (
        .clk         (clk),
        .req         (mem_req),
        .rd_data_reg (rd_data)
    );

    // Hold the result until the downstream transfer; load a new one when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_data_reg.status,
                                         m_data_reg.cursor_index,
                                         m_data_reg.item_count,
                                         m_data_reg.has_current,
                                         m_data_reg.current_value});

endmodule
